FILE: rtl/core/rrqs_pkg.sv
// Package for the round-robin quantum scheduler.
// Holds widths, queue depth, status and function codes, and the cell control struct.
// No dependencies.
package rrqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int BURST_W     = 16;
    localparam int TIME_W      = 32;

    localparam logic [BURST_W-1:0] QUANTUM_RESET = BURST_W'(10);

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_SLICE = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_FULL  = 2'd1,
        ST_RAN   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic shift;  // take the neighbor's entry
        logic load;   // take the write data (wins over shift)
    } cell_ctrl_t;

endpackage

FILE: rtl/core/round_robin_quantum_scheduler.sv
// Round-robin scheduler with a time quantum. Each input transaction (add a task, or run one slice)
// gives exactly one result transaction, in the cycle after acceptance; a new transaction is taken
// every cycle as long as the result register is free or being drained, so the rate is one item
// per clock. The ready queue is a row of 16 cells that shift toward the head on each pop, so the
// oldest task always sits in cell 0; a requeued task is written back at the tail in the same cycle.
// The user must write the quantum over the cfg channel only while idle; the block does not enforce
// this. A value of zero acts as one. Elapsed time saturates at all ones. Depends on rrqs_pkg, rrqs_queue.
module round_robin_quantum_scheduler
    import rrqs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BURST_W-1:0] cfg_quantum,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [ID_W-1:0]    s_task_id,
    input  logic [BURST_W-1:0] s_burst,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [ID_W-1:0]    m_run_task,
    output logic [BURST_W-1:0] m_run_length,
    output logic [TIME_W-1:0]  m_time_now,
    output logic               m_finished
);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic [BURST_W-1:0] quantum_reg;
    logic               m_valid_reg;
    status_t            status_reg, status_next;
    logic [ID_W-1:0]    run_task_reg, run_task_next;
    logic [BURST_W-1:0] run_len_reg, run_len_next;
    logic [TIME_W-1:0]  time_reg;
    logic               finished_reg, finished_next;

    logic               accept;
    logic               q_full, q_empty;
    logic [BURST_W-1:0] q_eff, slice_len, left_rem;
    logic [TIME_W:0]    time_sum;
    logic [ID_W-1:0]    head_id;
    logic [BURST_W-1:0] head_rem;
    logic               q_shift, q_wr_en;
    logic [IDX_W-1:0]   q_wr_pos;
    logic [ID_W-1:0]    q_wr_id;
    logic [BURST_W-1:0] q_wr_rem;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);

    assign q_eff     = (quantum_reg == '0) ? BURST_W'(1) : quantum_reg;
    assign slice_len = (head_rem <= q_eff) ? head_rem : q_eff;
    assign left_rem  = head_rem - slice_len;
    assign time_sum  = {1'b0, elapsed_reg} + {{(TIME_W + 1 - BURST_W){1'b0}}, slice_len};

    always_comb begin
        count_next    = count_reg;
        elapsed_next  = elapsed_reg;
        status_next   = ST_EMPTY;
        run_task_next = '0;
        run_len_next  = '0;
        finished_next = 1'b0;
        q_shift       = 1'b0;
        q_wr_en       = 1'b0;
        q_wr_pos      = count_reg[IDX_W-1:0];
        q_wr_id       = s_task_id;
        q_wr_rem      = s_burst;
        if (s_func == FUNC_ADD) begin
            if (q_full) begin
                status_next = ST_FULL;
            end else begin
                status_next = ST_ADDED;
                q_wr_en     = accept;
                count_next  = count_reg + CNT_W'(1);
            end
        end else if (!q_empty) begin
            status_next   = ST_RAN;
            run_task_next = head_id;
            run_len_next  = slice_len;
            elapsed_next  = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
            q_shift       = accept;
            // after the pop the tail slot is one below the old count
            q_wr_pos      = IDX_W'(count_reg - CNT_W'(1));
            q_wr_id       = head_id;
            q_wr_rem      = left_rem;
            if (left_rem != '0) begin
                q_wr_en = accept;
            end else begin
                finished_next = 1'b1;
                count_next    = count_reg - CNT_W'(1);
            end
        end
    end

    rrqs_queue u_queue (
        .aclk     (aclk),
        .shift    (q_shift),
        .wr_en    (q_wr_en),
        .wr_pos   (q_wr_pos),
        .wr_id    (q_wr_id),
        .wr_rem   (q_wr_rem),
        .head_id  (head_id),
        .head_rem (head_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            elapsed_reg <= '0;
            quantum_reg <= QUANTUM_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                quantum_reg <= cfg_quantum;
            end
            if (accept) begin
                count_reg   <= count_next;
                elapsed_reg <= elapsed_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg   <= status_next;
            run_task_reg <= run_task_next;
            run_len_reg  <= run_len_next;
            time_reg     <= elapsed_next;
            finished_reg <= finished_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_run_task   = run_task_reg;
    assign m_run_length = run_len_reg;
    assign m_time_now   = time_reg;
    assign m_finished   = finished_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_empty_slice: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_func == FUNC_SLICE && q_empty |=> m_valid && m_status == ST_EMPTY)
        else $error("slice on empty queue not reported empty");

    a_time_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> elapsed_reg >= $past(elapsed_reg))
        else $error("elapsed time went backward");

    a_finished_ran: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> m_status == ST_RAN)
        else $error("finished flag without a slice");

endmodule

FILE: rtl/core/rrqs_cell.sv
// One queue cell: holds a task id and its remaining burst.
// Depends on rrqs_pkg.
module rrqs_cell
    import rrqs_pkg::*;
(
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic [ID_W-1:0]    nbr_id,
    input  logic [BURST_W-1:0] nbr_rem,
    input  logic [ID_W-1:0]    wr_id,
    input  logic [BURST_W-1:0] wr_rem,
    output logic [ID_W-1:0]    id,
    output logic [BURST_W-1:0] rem
);

    logic [ID_W-1:0]    id_reg;
    logic [BURST_W-1:0] rem_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            id_reg  <= wr_id;
            rem_reg <= wr_rem;
        end else if (ctrl.shift) begin
            id_reg  <= nbr_id;
            rem_reg <= nbr_rem;
        end
    end

    assign id  = id_reg;
    assign rem = rem_reg;

endmodule

FILE: rtl/core/rrqs_queue.sv
// Ready queue built as a row of rrqs_cell; cell 0 holds the oldest task.
// A pop shifts every cell one place toward the head. Depends on rrqs_pkg, rrqs_cell.
module rrqs_queue
    import rrqs_pkg::*;
(
    input  logic               aclk,
    input  logic               shift,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_pos,
    input  logic [ID_W-1:0]    wr_id,
    input  logic [BURST_W-1:0] wr_rem,
    output logic [ID_W-1:0]    head_id,
    output logic [BURST_W-1:0] head_rem
);

    logic [ID_W-1:0]    id_arr  [QUEUE_DEPTH];
    logic [BURST_W-1:0] rem_arr [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        cell_ctrl_t         ctrl;
        logic [ID_W-1:0]    nbr_id;
        logic [BURST_W-1:0] nbr_rem;

        assign ctrl.shift = shift;
        assign ctrl.load  = wr_en && (wr_pos == IDX_W'(i));

        if (i < QUEUE_DEPTH - 1) begin : g_mid
            assign nbr_id  = id_arr[i+1];
            assign nbr_rem = rem_arr[i+1];
        end else begin : g_last
            // nothing behind the last cell; its content is dead after a shift
            assign nbr_id  = wr_id;
            assign nbr_rem = wr_rem;
        end

        rrqs_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .nbr_id  (nbr_id),
            .nbr_rem (nbr_rem),
            .wr_id   (wr_id),
            .wr_rem  (wr_rem),
            .id      (id_arr[i]),
            .rem     (rem_arr[i])
        );
    end

    assign head_id  = id_arr[0];
    assign head_rem = rem_arr[0];

endmodule

FILE: verif/tb_round_robin_quantum_scheduler.sv
`timescale 1ns / 100ps
// Testbench for round_robin_quantum_scheduler: directed and random add/slice traffic against a
// queue-based predictor of the ready queue, elapsed time and quantum, with random stalls.
// Depends on rrqs_pkg and the scheduler RTL.
module tb_round_robin_quantum_scheduler;
    import rrqs_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_ERR_LINES  = 100;

    typedef struct {
        status_t              status;
        logic [ID_W-1:0]      run_task;
        logic [BURST_W-1:0]   run_length;
        logic [TIME_W-1:0]    time_now;
        logic                 finished;
    } sched_result_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [BURST_W-1:0] cfg_quantum = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic               s_func      = FUNC_ADD;
    logic [ID_W-1:0]    s_task_id   = '0;
    logic [BURST_W-1:0] s_burst     = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [1:0]         m_status;
    logic [ID_W-1:0]    m_run_task;
    logic [BURST_W-1:0] m_run_length;
    logic [TIME_W-1:0]  m_time_now;
    logic               m_finished;

    // predictor state
    logic [ID_W-1:0]    ready_ids[$];
    logic [BURST_W-1:0] ready_left[$];
    logic [TIME_W-1:0]  clock_time = '0;
    logic [BURST_W-1:0] quantum_now = QUANTUM_RESET;
    sched_result_t      pending_results[$];

    int  err_cnt      = 0;
    int  stuck_cycles = 0;
    int  stall_left   = 0;
    bit  idle_en      = 1'b1;

    round_robin_quantum_scheduler u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_quantum  (cfg_quantum),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_task_id    (s_task_id),
        .s_burst      (s_burst),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_run_task   (m_run_task),
        .m_run_length (m_run_length),
        .m_time_now   (m_time_now),
        .m_finished   (m_finished)
    );

    always #HALF_PERIOD aclk = ~aclk;

    task automatic report_err(input string msg);
        if (err_cnt < MAX_ERR_LINES) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want) begin
            report_err($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    // One accepted transaction: update the scheduler image and queue the expected result.
    task automatic predict_schedule(input logic func_in, input logic [ID_W-1:0] id_in,
                                    input logic [BURST_W-1:0] burst_in);
        sched_result_t      r;
        logic [BURST_W-1:0] q;
        logic [BURST_W-1:0] rem;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] len;
        logic [TIME_W:0]    sum;
        r = '{ST_ADDED, '0, '0, clock_time, 1'b0};
        if (func_in == FUNC_ADD) begin
            if (ready_ids.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                ready_ids.push_back(id_in);
                ready_left.push_back(burst_in);
            end
        end else if (ready_ids.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            q   = (quantum_now == '0) ? BURST_W'(1) : quantum_now;
            id  = ready_ids.pop_front();
            rem = ready_left.pop_front();
            len = (rem <= q) ? rem : q;
            sum = {1'b0, clock_time} + {{(TIME_W + 1 - BURST_W){1'b0}}, len};
            clock_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            if (rem > len) begin
                ready_ids.push_back(id);
                ready_left.push_back(rem - len);
            end else begin
                r.finished = 1'b1;
            end
            r.status     = ST_RAN;
            r.run_task   = id;
            r.run_length = len;
            r.time_now   = clock_time;
        end
        pending_results.push_back(r);
    endtask

    task automatic send_item(input logic func_in, input logic [ID_W-1:0] id_in,
                             input logic [BURST_W-1:0] burst_in);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= func_in;
        s_task_id <= id_in;
        s_burst   <= burst_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_schedule(func_in, id_in, burst_in);
    endtask

    task automatic run_slice();
        send_item(FUNC_SLICE, ID_W'($urandom), BURST_W'($urandom));
    endtask

    task automatic drain_queue();
        while (ready_ids.size() != 0) run_slice();
    endtask

    // hold off the sender until every expected result has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_quantum(input logic [BURST_W-1:0] value);
        settle();
        cfg_valid   <= 1'b1;
        cfg_quantum <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        quantum_now = value;
    endtask

    function automatic logic [BURST_W-1:0] pick_burst();
        if ($urandom_range(0, 15) == 0) return BURST_W'($urandom);
        return BURST_W'($urandom_range(0, 40));
    endfunction

    // Slice on empty queue, zero burst, extreme ids and bursts, burst equal to the quantum.
    task automatic test_basic_ops();
        run_slice();
        send_item(FUNC_ADD, 8'h00, 16'd0);
        send_item(FUNC_ADD, 8'hFF, 16'hFFFF);
        send_item(FUNC_ADD, 8'h5A, 16'd10);
        send_item(FUNC_ADD, 8'hA5, 16'd11);
        repeat (5) run_slice();
    endtask

    // Fill to capacity, overflow, then pop one and add two more (the second overflows), and drain to empty.
    task automatic test_queue_full();
        write_quantum(16'hFFFF);
        drain_queue();
        for (int i = 0; i <= QUEUE_DEPTH; i++) begin
            send_item(FUNC_ADD, ID_W'(i * 13), BURST_W'(i));
        end
        run_slice();
        send_item(FUNC_ADD, 8'hEE, 16'd5);
        send_item(FUNC_ADD, 8'h77, 16'd1);
        drain_queue();
        run_slice();
    endtask

    // Zero quantum acts as one; then minimum and maximum quantum.
    task automatic test_quantum_extremes();
        write_quantum(16'd0);
        send_item(FUNC_ADD, 8'h11, 16'd3);
        send_item(FUNC_ADD, 8'h22, 16'd1);
        drain_queue();
        write_quantum(16'd1);
        send_item(FUNC_ADD, 8'h33, 16'd2);
        drain_queue();
        write_quantum(16'hFFFF);
        send_item(FUNC_ADD, 8'h44, 16'hFFFE);
        drain_queue();
    endtask

    // Alternating fill-heavy and drain-heavy phases, each with a fresh quantum.
    task automatic test_random_traffic();
        logic [BURST_W-1:0] q;
        int                 add_pct;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0:       q = BURST_W'($urandom_range(1, 16));
                1:       q = BURST_W'($urandom_range(0, 1));
                2:       q = BURST_W'($urandom);
                default: q = BURST_W'($urandom_range(17, 300));
            endcase
            write_quantum(q);
            idle_en = (phase != 3);
            add_pct = (phase % 2 == 0) ? 70 : 35;
            for (int n = 0; n < 125; n++) begin
                if ($urandom_range(0, 99) < add_pct) begin
                    send_item(FUNC_ADD, ID_W'($urandom), pick_burst());
                end else begin
                    run_slice();
                end
            end
        end
    endtask

    // Full-rate stretch with no idling on either side: long tasks, then mixed bursts.
    task automatic test_full_rate();
        idle_en = 1'b0;
        write_quantum(16'hFFFF);
        for (int n = 0; n < 20; n++) begin
            if (ready_ids.size() < QUEUE_DEPTH) begin
                send_item(FUNC_ADD, ID_W'($urandom), 16'hFFFF);
            end
            run_slice();
        end
        for (int n = 0; n < 20; n++) begin
            send_item(FUNC_ADD, ID_W'($urandom), pick_burst());
            run_slice();
        end
        drain_queue();
        run_slice();
    endtask

    always @(posedge aclk) begin : result_check
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_err($sformatf("unexpected result status %0d task 0x%0h",
                                     m_status, m_run_task));
            end else begin
                want = pending_results.pop_front();
                check_field("status", TIME_W'(m_status), TIME_W'(want.status));
                check_field("run_task", TIME_W'(m_run_task), TIME_W'(want.run_task));
                check_field("run_length", TIME_W'(m_run_length), TIME_W'(want.run_length));
                check_field("time_now", m_time_now, want.time_now);
                check_field("finished", TIME_W'(m_finished), TIME_W'(want.finished));
            end
        end
    end

    // result-side backpressure in random bursts
    always @(posedge aclk) begin : sink_stall
        int nxt;
        nxt = stall_left;
        if (nxt != 0) begin
            nxt--;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            nxt = $urandom_range(1, 9);
        end
        stall_left <= nxt;
        m_ready    <= (nxt == 0);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("** round_robin_quantum_scheduler: FAILED **");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_ops();
        test_queue_full();
        test_quantum_extremes();
        test_random_traffic();
        test_full_rate();
        settle();
        if (err_cnt == 0) begin
            $display("** round_robin_quantum_scheduler: PASSED **");
        end else begin
            $display("** round_robin_quantum_scheduler: FAILED **");
        end
        $finish;
    end

endmodule
